@@ rtl/core/aefr_pkg.sv @@
// Shared types and constants for the ATIS event frame reconstruction block.
`default_nettype none
package aefr_pkg;

  localparam int unsigned DEF_IMG_WIDTH  = 256;
  localparam int unsigned DEF_IMG_HEIGHT = 256;
  localparam int unsigned DEF_FRAC_BITS  = 16;

  localparam logic [1:0] CFG_MAX_INTEGRATION = 2'd0;
  localparam logic [1:0] CFG_GRAY_THRESHOLD  = 2'd1;
  localparam logic [1:0] CFG_TOTAL_FRAMES    = 2'd2;

  localparam logic [5:0]  RST_MAX_INTEGRATION = 6'd8;
  localparam logic [15:0] RST_GRAY_THRESHOLD  = 16'd255;
  localparam logic [15:0] RST_TOTAL_FRAMES    = 16'hFFFF;

  localparam logic OP_EVENT = 1'b0;
  localparam logic OP_END   = 1'b1;

  localparam logic POL_START = 1'b0;
  localparam logic POL_END   = 1'b1;

  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  localparam logic [7:0] GRAY_MAX = 8'hFF;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_READ,
    S_CHECK,
    S_DIV,
    S_LOOP,
    S_FINISH
  } state_t;

endpackage
`default_nettype wire

@@ rtl/core/atis_event_frame_reconstruct.sv @@
// Top level: sequencer, pixel store and result staging for frame reconstruction.
// An end event that writes runs the 8-step shared divider, then walks the frames spanned
// by the exposure (at most max_integration). Output stalls hold the sequencer.
// After rst a clearing pass zeroes the pixel store; only configuration writes are taken
// then. Reset restores defaults.
`default_nettype none
module atis_event_frame_reconstruct
  import aefr_pkg::*;
#(
  parameter int unsigned IMG_WIDTH  = DEF_IMG_WIDTH,
  parameter int unsigned IMG_HEIGHT = DEF_IMG_HEIGHT,
  parameter int unsigned FRAC_BITS  = DEF_FRAC_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        op,
  input  wire logic [7:0]  pix_x,
  input  wire logic [7:0]  pix_y,
  input  wire logic [31:0] stamp,
  input  wire logic        polarity,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             kind,
  output logic [15:0]      frame_index,
  output logic [7:0]       out_x,
  output logic [7:0]       out_y,
  output logic [7:0]       gray,
  output logic             last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int unsigned NPIX = IMG_WIDTH * IMG_HEIGHT;
  localparam int unsigned AW   = (NPIX > 1) ? $clog2(NPIX) : 1;
  localparam int unsigned CW   = (17 + FRAC_BITS > 33) ? 17 + FRAC_BITS : 33;
  localparam int unsigned FW   = 33 - FRAC_BITS;
  localparam int unsigned NW   = 16 + FRAC_BITS;
  localparam int unsigned DW   = 6 + FRAC_BITS;
  localparam logic [32:0] ROUND_UP = 33'((64'd1 << FRAC_BITS) - 64'd1);

  state_t state, state_next;

  logic [5:0]  max_integration;
  logic [15:0] gray_threshold;
  logic [15:0] total_frames;

  logic        op_r;
  logic [7:0]  x_r;
  logic [7:0]  y_r;
  logic [31:0] t_r;
  logic        pol_r;

  logic [15:0]   lowest;
  logic          stopped;
  logic [AW-1:0] clr_cnt;
  logic [FW-1:0] f;

  logic        pend_valid;
  logic        pend_kind;
  logic [15:0] pend_frame;
  logic [7:0]  pend_x;
  logic [7:0]  pend_y;
  logic [7:0]  pend_gray;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [32:0]   ram_wdata;
  logic [32:0]   ram_rdata;
  logic [AW-1:0] pix_addr;
  logic [16:0]   pix_lin;

  logic          div_start;
  logic          div_busy;
  logic [7:0]    div_quot;

  logic          push;
  logic          push_ok;
  logic          push_kind;
  logic [15:0]   push_frame;
  logic          flush;
  logic          out_free;
  logic          f_step;

  logic [16:0]   win_end;
  logic [16:0]   stop_end;
  logic [32:0]   ceil_t;
  logic [15:0]   new_lowest;
  logic          end_cond;
  logic          adv_cond;
  logic          in_image;
  logic [31:0]   s_val;
  logic [31:0]   interval;
  logic          int_ok;
  logic          f_below;
  logic          f_in_win;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_integration <= RST_MAX_INTEGRATION;
      gray_threshold  <= RST_GRAY_THRESHOLD;
      total_frames    <= RST_TOTAL_FRAMES;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_INTEGRATION: max_integration <= cfg_data[5:0];
        CFG_GRAY_THRESHOLD:  gray_threshold  <= cfg_data[15:0];
        CFG_TOTAL_FRAMES:    total_frames    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign win_end  = {1'b0, lowest} + 17'(max_integration) + 17'd2;
  assign ceil_t   = (33'(t_r) + ROUND_UP) >> FRAC_BITS;
  assign new_lowest = 16'(ceil_t) - 16'(max_integration);
  assign end_cond = (op_r == OP_END) || (CW'(t_r) >= (CW'(total_frames) << FRAC_BITS));
  assign adv_cond = CW'(t_r) > (CW'(win_end) << FRAC_BITS);
  assign in_image = (32'(x_r) < 32'(IMG_WIDTH)) && (32'(y_r) < 32'(IMG_HEIGHT));
  assign pix_lin  = 17'(x_r) * 17'(IMG_HEIGHT) + 17'(y_r);
  assign pix_addr = pix_lin[AW-1:0];

  always_comb begin
    stop_end = win_end;
    if (stop_end > {1'b0, total_frames}) begin
      stop_end = {1'b0, total_frames};
    end
    if (stop_end < {1'b0, lowest}) begin
      stop_end = {1'b0, lowest};
    end
  end

  assign s_val    = ram_rdata[31:0];
  assign interval = t_r - s_val;
  assign int_ok   = ram_rdata[32] && (t_r > s_val) &&
                    (CW'(interval) <= (CW'(max_integration) << FRAC_BITS));
  assign f_below  = (CW'(f) << FRAC_BITS) < CW'(t_r);
  assign f_in_win = (CW'(f) >= CW'(lowest)) && (CW'(f) < CW'(win_end));

  assign out_free = !out_valid || !out_stall;
  assign push_ok  = !pend_valid || out_free;

  aefr_ram #(
    .WIDTH(33),
    .DEPTH(NPIX)
  ) u_pix_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pix_addr),
    .rdata (ram_rdata)
  );

  aefr_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({gray_threshold, FRAC_BITS'(0)}),
    .den   (interval[DW-1:0]),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_cnt == AW'(NPIX - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_EVAL;
      end
      S_EVAL: begin
        if (stopped || end_cond || !in_image) state_next = S_FINISH;
        else state_next = S_READ;
      end
      S_READ: begin
        state_next = (pol_r == POL_START) ? S_FINISH : S_CHECK;
      end
      S_CHECK: begin
        state_next = int_ok ? S_DIV : S_FINISH;
      end
      S_DIV: begin
        if (!div_busy) state_next = S_LOOP;
      end
      S_LOOP: begin
        if (!f_below) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!pend_valid || out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    push       = 1'b0;
    push_kind  = KIND_WRITE;
    push_frame = 16'd0;
    flush      = 1'b0;
    f_step     = 1'b0;
    div_start  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = pix_addr;
    ram_wdata  = {1'b1, t_r};
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = 33'd0;
      end
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_EVAL: begin
        if (!stopped) begin
          if (end_cond) begin
            push       = 1'b1;
            push_kind  = KIND_ADVANCE;
            push_frame = stop_end[15:0];
          end else if (adv_cond) begin
            push       = 1'b1;
            push_kind  = KIND_ADVANCE;
            push_frame = new_lowest;
          end
        end
      end
      S_READ: begin
        ram_we = (pol_r == POL_START);
      end
      S_CHECK: begin
        ram_we    = 1'b1;
        ram_wdata = {1'b0, s_val};
        div_start = int_ok;
      end
      S_DIV: ;
      S_LOOP: begin
        if (f_below) begin
          if (f_in_win) begin
            push       = 1'b1;
            push_kind  = KIND_WRITE;
            push_frame = 16'(f);
            f_step     = push_ok;
          end else begin
            f_step = 1'b1;
          end
        end
      end
      S_FINISH: begin
        flush = pend_valid && out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      lowest     <= 16'd0;
      stopped    <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (state == S_EVAL && !stopped) begin
        if (end_cond) begin
          stopped <= 1'b1;
        end else if (adv_cond) begin
          lowest <= new_lowest;
        end
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (push && push_ok) begin
        pend_valid <= 1'b1;
        if (pend_valid) begin
          out_valid <= 1'b1;
        end
      end else if (flush) begin
        pend_valid <= 1'b0;
        out_valid  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op_r  <= op;
      x_r   <= pix_x;
      y_r   <= pix_y;
      t_r   <= stamp;
      pol_r <= polarity;
    end
    if (state == S_CHECK) begin
      f <= FW'((33'(s_val) + ROUND_UP) >> FRAC_BITS);
    end else if (f_step) begin
      f <= f + FW'(1);
    end
    if ((push && push_ok && pend_valid) || flush) begin
      kind        <= pend_kind;
      frame_index <= pend_frame;
      out_x       <= pend_x;
      out_y       <= pend_y;
      gray        <= pend_gray;
      last        <= flush;
    end
    if (push && push_ok) begin
      pend_kind  <= push_kind;
      pend_frame <= push_frame;
      pend_x     <= (push_kind == KIND_WRITE) ? x_r : 8'd0;
      pend_y     <= (push_kind == KIND_WRITE) ? y_r : 8'd0;
      pend_gray  <= (push_kind == KIND_WRITE) ? div_quot : 8'd0;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/aefr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module aefr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/core/aefr_div.sv @@
// Shared restoring divider: one quotient bit per cycle, result saturated at 255.
`default_nettype none
module aefr_div
  import aefr_pkg::*;
#(
  parameter int unsigned FRAC_BITS = DEF_FRAC_BITS,
  localparam int unsigned NW = 16 + FRAC_BITS,
  localparam int unsigned DW = 6 + FRAC_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               busy,
  output logic [7:0]         quot
);

  logic [NW-1:0] rem;
  logic [NW-1:0] dsh;
  logic [7:0]    q;
  logic          sat;
  logic [3:0]    cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 4'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 4'd8;
      rem  <= num;
      dsh  <= NW'(den) << 7;
      sat  <= (num >= (NW'(den) << 8));
      q    <= 8'd0;
    end else if (busy) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        q   <= {q[6:0], 1'b1};
      end else begin
        q   <= {q[6:0], 1'b0};
      end
      dsh <= dsh >> 1;
      cnt <= cnt - 4'd1;
      if (cnt == 4'd1) begin
        busy <= 1'b0;
      end
    end
  end

  assign quot = sat ? GRAY_MAX : q;

endmodule
`default_nettype wire

@@ tb/aefr_checker.sv @@
// Checker for the frame reconstruction block: tracks pixel state and compares every result.
`timescale 1ns / 1ps
module aefr_checker
  import aefr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic        op,
  input  wire logic [7:0]  pix_x,
  input  wire logic [7:0]  pix_y,
  input  wire logic [31:0] stamp,
  input  wire logic        polarity,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic        kind,
  input  wire logic [15:0] frame_index,
  input  wire logic [7:0]  out_x,
  input  wire logic [7:0]  out_y,
  input  wire logic [7:0]  gray,
  input  wire logic        last,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output int               mismatches,
  output int               pending
);

  typedef struct packed {
    logic        kind;
    logic [15:0] frame;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  gray;
    logic        last;
  } pix_result_t;

  pix_result_t results_q[$];

  logic [5:0]  max_int;
  logic [15:0] threshold;
  logic [15:0] frames_total;
  bit          armed_map[65536];
  logic [31:0] start_map[65536];
  logic [15:0] low_frame;
  bit          halted;

  function automatic pix_result_t mk(logic k, logic [15:0] f, logic [7:0] x, logic [7:0] y,
                                     logic [7:0] g);
    pix_result_t r;
    r.kind = k;
    r.frame = f;
    r.x = x;
    r.y = y;
    r.gray = g;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic predict_event(logic o, logic [7:0] x, logic [7:0] y, logic [31:0] t,
                               logic pol);
    longint unsigned win, fend, tt, s, g, f, ceil_t;
    int n;
    int idx;
    pix_result_t batch[$];
    win = longint'(max_int) + 2;
    tt = t;
    n = 0;
    idx = {x, y};
    if (halted) return;
    if (o == OP_END || tt >= (longint'(frames_total) << 16)) begin
      fend = longint'(low_frame) + win;
      if (fend > frames_total) fend = frames_total;
      if (fend < low_frame) fend = low_frame;
      batch.push_back(mk(KIND_ADVANCE, fend[15:0], 8'd0, 8'd0, 8'd0));
      halted = 1'b1;
    end else begin
      if (tt > ((longint'(low_frame) + win) << 16)) begin
        ceil_t = (tt + 64'hFFFF) >> 16;
        low_frame = 16'(ceil_t - max_int);
        batch.push_back(mk(KIND_ADVANCE, low_frame, 8'd0, 8'd0, 8'd0));
      end
      if (pol == POL_START) begin
        armed_map[idx] = 1'b1;
        start_map[idx] = t;
      end else begin
        s = start_map[idx];
        if (armed_map[idx] && tt > s && (tt - s) <= (longint'(max_int) << 16)) begin
          g = (longint'(threshold) << 16) / (tt - s);
          if (g > 255) g = 255;
          n = 0;
          for (f = (s + 64'hFFFF) >> 16; (f << 16) < tt; f++) begin
            if (f < low_frame || f >= longint'(low_frame) + win) continue;
            if (n >= 64) break;
            batch.push_back(mk(KIND_WRITE, f[15:0], x, y, g[7:0]));
            n++;
          end
        end
        armed_map[idx] = 1'b0;
      end
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) results_q.push_back(batch[i]);
  endtask

  always @(posedge clk) begin
    pix_result_t want;
    if (rst) begin
      max_int = RST_MAX_INTEGRATION;
      threshold = RST_GRAY_THRESHOLD;
      frames_total = RST_TOTAL_FRAMES;
      for (int i = 0; i < 65536; i++) armed_map[i] = 1'b0;
      low_frame = 16'd0;
      halted = 1'b0;
      results_q.delete();
      mismatches = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result transfer: kind %0d frame %0d x %0d y %0d gray %0d",
                     kind, frame_index, out_x, out_y, gray);
        end else begin
          want = results_q.pop_front();
          if (want.kind !== kind || want.frame !== frame_index || want.x !== out_x ||
              want.y !== out_y || want.gray !== gray || want.last !== last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: exp k%0d f%0d x%0d y%0d g%0d l%0d, got k%0d f%0d x%0d y%0d g%0d l%0d",
                       want.kind, want.frame, want.x, want.y, want.gray, want.last,
                       kind, frame_index, out_x, out_y, gray, last);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_INTEGRATION: max_int = cfg_data[5:0];
          CFG_GRAY_THRESHOLD:  threshold = cfg_data[15:0];
          CFG_TOTAL_FRAMES:    frames_total = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_event(op, pix_x, pix_y, stamp, polarity);
    end
    pending = results_q.size();
  end

endmodule

@@ tb/testbench.sv @@
// Testbench top: clock, reset, stimulus and verdict for the frame reconstruction block.
`timescale 1ns / 1ps
module testbench;
  import aefr_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        op = OP_EVENT;
  logic [7:0]  pix_x = 8'd0;
  logic [7:0]  pix_y = 8'd0;
  logic [31:0] stamp = 32'd0;
  logic        polarity = POL_START;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = CFG_MAX_INTEGRATION;
  logic [31:0] cfg_data = 32'd0;
  wire         in_stall, out_valid, kind, last, cfg_ready;
  wire  [15:0] frame_index;
  wire  [7:0]  out_x, out_y, gray;
  int          mismatches, pending;
  int          cycles = 0;
  bit          tx_quiet = 1'b0, rx_quiet = 1'b0, rx_hold = 1'b0;
  logic [31:0] now;
  logic [15:0] pool[4];
  logic [5:0]  phase_max[4];
  logic [15:0] phase_thr[4];

  atis_event_frame_reconstruct dut (.*);
  aefr_checker u_checker (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int n;
    forever begin
      if (rx_hold) begin
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
        rx_hold = 1'b0;
      end
      n = rx_quiet ? 0 : $urandom_range(0, 17);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall) && !rx_hold);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic send(logic o, logic [7:0] x, logic [7:0] y, logic [31:0] t, logic pol);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    pix_x <= x;
    pix_y <= y;
    stamp <= t;
    polarity <= pol;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic random_event();
    int r;
    logic [15:0] p;
    logic [31:0] t;
    r = $urandom_range(0, 99);
    p = (r < 6) ? 16'($urandom) : pool[$urandom_range(0, 3)];
    if ($urandom_range(0, 19) == 0)
      now = now + $urandom_range(0, 32'h0800_0000);
    else
      now = now + $urandom_range(0, 32'h0003_0000);
    if (now > 32'hFFF0_0000) now = 32'hFFF0_0000;
    t = now;
    if (r >= 94 && now > 32'h0004_0000) t = now - $urandom_range(0, 32'h0004_0000);
    send(OP_EVENT, p[15:8], p[7:0], t, $urandom_range(0, 1));
  endtask

  initial begin
    phase_max[0] = 6'd8;   phase_thr[0] = 16'd255;
    phase_max[1] = 6'd1;   phase_thr[1] = 16'd0;
    phase_max[2] = 6'd62;  phase_thr[2] = 16'hFFFF;
    phase_max[3] = 6'($urandom_range(2, 61)); phase_thr[3] = 16'($urandom);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_MAX_INTEGRATION, {26'd0, phase_max[ph]});
      write_reg(CFG_GRAY_THRESHOLD, {16'd0, phase_thr[ph]});
      if (ph == 0) write_reg(CFG_TOTAL_FRAMES, 32'h0000_FFFF);
      cfg_valid <= 1'b0;
      pool[0] = 16'h0000;
      pool[1] = 16'hFFFF;
      pool[2] = 16'($urandom);
      pool[3] = 16'($urandom);
      tx_quiet = (ph == 2);
      rx_quiet = (ph == 2);
      if (ph == 0) begin
        send(OP_EVENT, 8'd0, 8'd0, 32'h0000_8000, POL_START);
        send(OP_EVENT, 8'd0, 8'd0, 32'h0003_8000, POL_END);
        send(OP_EVENT, 8'd0, 8'd0, 32'h0003_8000, POL_END);
        send(OP_EVENT, 8'd255, 8'd255, 32'h0004_0000, POL_START);
        send(OP_EVENT, 8'd255, 8'd255, 32'h0004_0000, POL_END);
        send(OP_EVENT, 8'd255, 8'd0, 32'h0005_0000, POL_START);
        send(OP_EVENT, 8'd255, 8'd0, 32'h0004_8000, POL_END);
        send(OP_EVENT, 8'd0, 8'd255, 32'h0006_0000, POL_START);
        send(OP_EVENT, 8'd0, 8'd255, 32'h000E_0001, POL_END);
        send(OP_EVENT, 8'd1, 8'd1, 32'h000E_8000, POL_START);
        send(OP_EVENT, 8'd1, 8'd1, 32'h000F_4000, POL_END);
        send(OP_EVENT, 8'd1, 8'd1, 32'h000F_8000, POL_START);
        send(OP_EVENT, 8'd1, 8'd1, 32'h0010_8000, POL_END);
        send(OP_EVENT, 8'd2, 8'd2, 32'h0010_8000, POL_START);
        send(OP_EVENT, 8'd3, 8'd3, 32'h001A_8000, POL_START);
        send(OP_EVENT, 8'd2, 8'd2, 32'h0018_0000, POL_END);
        now = 32'h001A_8000;
      end
      if (ph == 3) now = now + 32'hE000_0000;
      if (ph == 1) rx_hold = 1'b1;
      for (int i = 0; i < 58; i++) random_event();
      settle();
    end
    send(OP_END, 8'($urandom), 8'($urandom), now, POL_START);
    settle();
    write_reg(CFG_TOTAL_FRAMES, 32'd0);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 4; i++) random_event();
    send(OP_EVENT, 8'd9, 8'd9, now, POL_END);
    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
